// ===== hw/rtl/leb_pkg.sv =====
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants for the line editing buffer: request and result
// layouts, command codes, and the RAM write bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package leb_pkg;

  localparam int BUF_BYTES = 256;
  localparam int CAP       = BUF_BYTES - 1;
  localparam int LEN_W     = $clog2(BUF_BYTES);
  localparam int ADDR_W    = LEN_W;
  localparam int CMP_W     = (LEN_W > 8) ? LEN_W : 8;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_DELETE    = 3'd1;
  localparam logic [2:0] OP_BACKSPACE = 3'd2;
  localparam logic [2:0] OP_LEFT      = 3'd3;
  localparam logic [2:0] OP_RIGHT     = 3'd4;
  localparam logic [2:0] OP_SET       = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;
  localparam logic [2:0] OP_READ      = 3'd7;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_in;
    logic [7:0] position;
  } leb_req_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] line_length;
    logic [7:0] cursor_pos;
    logic [7:0] char_under_cursor;
    logic [7:0] read_char;
  } leb_rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } leb_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/leb_ram.sv =====
// ----------------------------------------------------------------------------
// leb_ram
// Line byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module leb_ram
  import leb_pkg::*;
(
  input  wire logic              clk,
  input  wire leb_wr_t           wr,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic [7:0]             rdata
);

  logic [7:0] mem [0:CAP-1];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/leb_ctrl.sv =====
// ----------------------------------------------------------------------------
// leb_ctrl
// Command sequencer: bounds checks, length and cursor registers, the tail
// shift through the byte store, and the final lookups for the result.
// ----------------------------------------------------------------------------
`default_nettype none

module leb_ctrl
  import leb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire leb_req_t          request,
  output logic                   busy,
  output logic                   done,
  output leb_rsp_t               result,
  output leb_wr_t                wr,
  output logic [ADDR_W-1:0]      raddr,
  input  wire logic [7:0]        rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_FIN1  = 3'd3;
  localparam logic [2:0] S_FIN2  = 3'd4;
  localparam logic [2:0] S_FIN3  = 3'd5;

  logic [2:0]        state;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  cur;
  logic [2:0]        op;
  logic [7:0]        pos;
  logic [7:0]        ch;
  logic              ok;
  logic              up;
  logic              pend;
  logic [LEN_W-1:0]  cnt;
  logic [ADDR_W-1:0] rptr;
  logic [ADDR_W-1:0] wa;
  logic [ADDR_W-1:0] put_addr;
  logic [7:0]        rd_char;

  assign busy = (state != S_IDLE);

  always_comb begin
    wr.we   = ((state == S_SHIFT) && pend) || (state == S_PUT);
    wr.addr = (state == S_PUT) ? put_addr : wa;
    wr.data = (state == S_PUT) ? ch : rdata;
    case (state)
      S_SHIFT: raddr = rptr;
      S_FIN1:  raddr = ADDR_W'(pos);
      default: raddr = ADDR_W'(cur);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      cur   <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op   <= request.req_type;
            pos  <= request.position;
            ch   <= request.char_in;
            pend <= 1'b0;
            ok   <= 1'b0;
            state <= S_FIN1;
            case (request.req_type)
              OP_INSERT: begin
                if (LEN_W'(CAP) > len) begin
                  ok       <= 1'b1;
                  len      <= len + LEN_W'(1);
                  cur      <= cur + LEN_W'(1);
                  put_addr <= ADDR_W'(cur);
                  if (len > cur) begin
                    rptr  <= ADDR_W'(len - LEN_W'(1));
                    cnt   <= len - cur;
                    up    <= 1'b1;
                    state <= S_SHIFT;
                  end else begin
                    state <= S_PUT;
                  end
                end
              end
              OP_DELETE: begin
                if (cur < len) begin
                  ok  <= 1'b1;
                  len <= len - LEN_W'(1);
                  if ((len - cur) > LEN_W'(1)) begin
                    rptr  <= ADDR_W'(cur + LEN_W'(1));
                    cnt   <= len - cur - LEN_W'(1);
                    up    <= 1'b0;
                    state <= S_SHIFT;
                  end
                end
              end
              OP_BACKSPACE: begin
                if (cur != '0) begin
                  ok  <= 1'b1;
                  len <= len - LEN_W'(1);
                  cur <= cur - LEN_W'(1);
                  if (len > cur) begin
                    rptr  <= ADDR_W'(cur);
                    cnt   <= len - cur;
                    up    <= 1'b0;
                    state <= S_SHIFT;
                  end
                end
              end
              OP_LEFT: begin
                if (cur != '0) begin
                  ok  <= 1'b1;
                  cur <= cur - LEN_W'(1);
                end
              end
              OP_RIGHT: begin
                if (cur < len) begin
                  ok  <= 1'b1;
                  cur <= cur + LEN_W'(1);
                end
              end
              OP_SET: begin
                if (CMP_W'(request.position) <= CMP_W'(len)) begin
                  ok  <= 1'b1;
                  cur <= LEN_W'(request.position);
                end
              end
              OP_CLEAR: begin
                ok  <= 1'b1;
                len <= '0;
                cur <= '0;
              end
              OP_READ: begin
                ok <= (CMP_W'(request.position) < CMP_W'(len));
              end
              default: begin
                ok <= 1'b0;
              end
            endcase
          end
        end
        S_SHIFT: begin
          pend <= (cnt != '0);
          if (cnt != '0) begin
            rptr <= up ? rptr - ADDR_W'(1) : rptr + ADDR_W'(1);
            wa   <= up ? rptr + ADDR_W'(1) : rptr - ADDR_W'(1);
            cnt  <= cnt - LEN_W'(1);
          end else begin
            state <= (op == OP_INSERT) ? S_PUT : S_FIN1;
          end
        end
        S_PUT: begin
          state <= S_FIN1;
        end
        S_FIN1: begin
          state <= S_FIN2;
        end
        S_FIN2: begin
          rd_char <= ((op == OP_READ) && ok) ? rdata : 8'd0;
          state   <= S_FIN3;
        end
        S_FIN3: begin
          result.accepted          <= ok;
          result.line_length       <= 8'(len);
          result.cursor_pos        <= 8'(cur);
          result.char_under_cursor <= (cur < len) ? rdata : 8'd0;
          result.read_char         <= rd_char;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// line_edit_buffer
// Console line editing store: insert, delete, backspace, cursor moves, clear
// and indexed read over a byte line held in a single-port-write RAM.
//
//   channel   handshake                 payload
//   request   start in, busy out        request (leb_req_t)
//   result    done out, one cycle       result  (leb_rsp_t)
//
// A command runs through the final lookup states before its result; a tail
// shift comes first when tail bytes move, and insert adds a write step.
// The shift streams one byte per cycle through the RAM read/write ports.
// Reset clears length and cursor; line bytes are left as they are.
// The result is shown for one cycle and a new request may start in it.
// ----------------------------------------------------------------------------
`default_nettype none

module line_edit_buffer
  import leb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire leb_req_t request,
  output logic          busy,
  output logic          done,
  output leb_rsp_t      result
);

  leb_wr_t           wr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  leb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .wr      (wr),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  leb_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/leb_check.sv =====
// ----------------------------------------------------------------------------
// leb_check
// Port-level checks for the line editing buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module leb_check
  import leb_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input wire leb_rsp_t result
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken without entering busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.cursor_pos <= result.line_length))
    else $error("cursor past line end");

  a_under_at_end: assert property (@(posedge clk) disable iff (rst)
    (done && (result.cursor_pos == result.line_length)) |->
      (result.char_under_cursor == 8'd0))
    else $error("byte under cursor not zero at line end");

  a_refused_read: assert property (@(posedge clk) disable iff (rst)
    (done && !result.accepted) |-> (result.read_char == 8'd0))
    else $error("read byte reported on refused request");

endmodule

bind line_edit_buffer leb_check u_leb_check (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);

`default_nettype wire

// ===== verif/line_edit_checker.sv =====
// ----------------------------------------------------------------------------
// line_edit_checker
// Watches the request and result channels of line_edit_buffer. It keeps its
// own copy of the line, length and cursor, works out the status that each
// accepted request must produce, and compares every result field by field
// with the oldest outstanding status.
// ----------------------------------------------------------------------------
module line_edit_checker
  import leb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  leb_req_t request,
  input  logic     done,
  input  leb_rsp_t result,
  output int       failures,
  output int       pending
);

  logic [7:0] line_bytes [0:CAP-1];
  int         text_len;
  int         cursor;
  leb_rsp_t   status_queue [$];
  leb_rsp_t   oldest;

  initial begin
    failures = 0;
    pending  = 0;
    text_len = 0;
    cursor   = 0;
  end

  function automatic leb_rsp_t edit_line(leb_req_t req);
    leb_rsp_t st;
    int       i;
    st = '0;
    case (req.req_type)
      OP_INSERT: begin
        if (text_len < CAP) begin
          for (i = text_len; i > cursor; i--) line_bytes[i] = line_bytes[i-1];
          line_bytes[cursor] = req.char_in;
          cursor++;
          text_len++;
          st.accepted = 1'b1;
        end
      end
      OP_DELETE: begin
        if (cursor < text_len) begin
          for (i = cursor; i + 1 < text_len; i++) line_bytes[i] = line_bytes[i+1];
          text_len--;
          st.accepted = 1'b1;
        end
      end
      OP_BACKSPACE: begin
        if (cursor > 0) begin
          for (i = cursor - 1; i + 1 < text_len; i++) line_bytes[i] = line_bytes[i+1];
          cursor--;
          text_len--;
          st.accepted = 1'b1;
        end
      end
      OP_LEFT: begin
        if (cursor > 0) begin
          cursor--;
          st.accepted = 1'b1;
        end
      end
      OP_RIGHT: begin
        if (cursor < text_len) begin
          cursor++;
          st.accepted = 1'b1;
        end
      end
      OP_SET: begin
        if (int'(req.position) <= text_len) begin
          cursor = int'(req.position);
          st.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        text_len = 0;
        cursor = 0;
        st.accepted = 1'b1;
      end
      default: begin
        if (int'(req.position) < text_len) begin
          st.read_char = line_bytes[req.position];
          st.accepted = 1'b1;
        end
      end
    endcase
    st.line_length = 8'(text_len);
    st.cursor_pos = 8'(cursor);
    st.char_under_cursor = (cursor < text_len) ? line_bytes[cursor] : 8'h00;
    return st;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      text_len = 0;
      cursor = 0;
      status_queue.delete();
    end else begin
      if (done) begin
        if (status_queue.size() == 0) begin
          $error("result with no request outstanding");
          failures++;
        end else begin
          oldest = status_queue.pop_front();
          if (result.accepted !== oldest.accepted) begin
            $error("accepted: expected %0d, got %0d", oldest.accepted, result.accepted);
            failures++;
          end
          if (result.line_length !== oldest.line_length) begin
            $error("line_length: expected %0d, got %0d",
                   oldest.line_length, result.line_length);
            failures++;
          end
          if (result.cursor_pos !== oldest.cursor_pos) begin
            $error("cursor_pos: expected %0d, got %0d", oldest.cursor_pos, result.cursor_pos);
            failures++;
          end
          if (result.char_under_cursor !== oldest.char_under_cursor) begin
            $error("char_under_cursor: expected %0h, got %0h",
                   oldest.char_under_cursor, result.char_under_cursor);
            failures++;
          end
          if (result.read_char !== oldest.read_char) begin
            $error("read_char: expected %0h, got %0h", oldest.read_char, result.read_char);
            failures++;
          end
        end
      end
      if (start && !busy) status_queue.push_back(edit_line(request));
    end
    pending = status_queue.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives line_edit_buffer with a short directed pass over every command and
// every refusal but a full-line insert, then random editing sessions: mostly
// typing with cursor moves, deletes and reads, plus up to two line fills to
// capacity. Request gaps vary at random; the checker beside it judges results.
// ----------------------------------------------------------------------------
module testbench;
  import leb_pkg::*;

  localparam int RANDOM_REQUESTS = 1450;
  localparam int DRAIN_CYCLES    = 600;
  localparam int CYCLE_LIMIT     = 4000000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  leb_req_t request = '0;
  logic     busy;
  logic     done;
  leb_rsp_t result;
  int       failures;
  int       pending;
  int       cycle_count = 0;
  int       sent = 0;
  bit       no_gaps = 1'b0;

  always #1 clk = ~clk;

  line_edit_buffer dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  line_edit_checker edit_check (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .failures (failures),
    .pending  (pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_cmd(logic [2:0] op, logic [7:0] ch, logic [7:0] pos);
    @(negedge clk);
    start = 1'b1;
    request = '{req_type: op, char_in: ch, position: pos};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic hold_off();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (!no_gaps) begin
      if (roll >= 92) gap = $urandom_range(10, 60);
      else if (roll >= 60) gap = $urandom_range(1, 4);
    end
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic edit_session(int steps, int reach);
    int         roll;
    logic [2:0] op;
    logic [7:0] pos;
    repeat (steps) begin
      roll = $urandom_range(0, 99);
      if (roll < 48) op = OP_INSERT;
      else if (roll < 56) op = OP_DELETE;
      else if (roll < 64) op = OP_BACKSPACE;
      else if (roll < 72) op = OP_LEFT;
      else if (roll < 80) op = OP_RIGHT;
      else if (roll < 88) op = OP_SET;
      else if (roll < 98) op = OP_READ;
      else op = OP_CLEAR;
      pos = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, reach));
      send_cmd(op, 8'($urandom_range(0, 255)), pos);
      hold_off();
    end
    send_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    hold_off();
  endtask

  task automatic fill_session();
    send_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    repeat (CAP + 3) begin
      send_cmd(OP_INSERT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      hold_off();
    end
    send_cmd(OP_READ, 8'h00, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'($urandom_range(1, CAP - 1)));
    send_cmd(OP_READ, 8'h00, 8'd254);
    send_cmd(OP_READ, 8'h00, 8'd255);
    send_cmd(OP_RIGHT, 8'h00, 8'h00);
    send_cmd(OP_SET, 8'h00, 8'd255);
    send_cmd(OP_SET, 8'h00, 8'($urandom_range(0, 20)));
    send_cmd(OP_DELETE, 8'h00, 8'h00);
    hold_off();
    send_cmd(OP_INSERT, 8'($urandom_range(0, 255)), 8'h00);
    send_cmd(OP_INSERT, 8'($urandom_range(0, 255)), 8'h00);
    send_cmd(OP_BACKSPACE, 8'h00, 8'h00);
    hold_off();
    send_cmd(OP_SET, 8'h00, 8'd254);
    send_cmd(OP_DELETE, 8'h00, 8'h00);
    send_cmd(OP_BACKSPACE, 8'h00, 8'h00);
    send_cmd(OP_CLEAR, 8'h00, 8'h00);
    hold_off();
  endtask

  initial begin
    int random_end;
    int fills;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_cmd(OP_DELETE, 8'h00, 8'h00);
    send_cmd(OP_BACKSPACE, 8'hFF, 8'hFF);
    send_cmd(OP_LEFT, 8'h00, 8'h00);
    send_cmd(OP_RIGHT, 8'h00, 8'h00);
    send_cmd(OP_READ, 8'h00, 8'd0);
    send_cmd(OP_SET, 8'h00, 8'd1);
    send_cmd(OP_SET, 8'h00, 8'd0);
    send_cmd(OP_INSERT, 8'h00, 8'h00);
    send_cmd(OP_INSERT, 8'hFF, 8'hFF);
    send_cmd(OP_INSERT, 8'hA5, 8'h00);
    send_cmd(OP_LEFT, 8'h00, 8'h00);
    send_cmd(OP_INSERT, 8'h5A, 8'h00);
    send_cmd(OP_READ, 8'h00, 8'd0);
    send_cmd(OP_READ, 8'h00, 8'd3);
    send_cmd(OP_READ, 8'h00, 8'd4);
    send_cmd(OP_READ, 8'h00, 8'd255);
    send_cmd(OP_SET, 8'h00, 8'd1);
    send_cmd(OP_DELETE, 8'h00, 8'h00);
    send_cmd(OP_BACKSPACE, 8'h00, 8'h00);
    send_cmd(OP_SET, 8'h00, 8'd2);
    send_cmd(OP_RIGHT, 8'h00, 8'h00);
    send_cmd(OP_SET, 8'h00, 8'd3);
    send_cmd(OP_CLEAR, 8'h00, 8'h00);
    send_cmd(OP_READ, 8'h00, 8'd0);

    random_end = sent + RANDOM_REQUESTS;
    fills = 0;
    while (sent < random_end) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      if (fills < 2 && sent > random_end - RANDOM_REQUESTS + (fills + 1) * 400) begin
        fill_session();
        fills++;
      end else begin
        edit_session($urandom_range(5, 60), $urandom_range(4, 40));
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/leb_pkg.sv
hw/rtl/leb_ram.sv
hw/rtl/leb_ctrl.sv
hw/rtl/line_edit_buffer.sv
hw/rtl/leb_check.sv
verif/line_edit_checker.sv
verif/testbench.sv
